// ===== rtl/core/cmws_pkg.sv =====
// ----------------------------------------------------------------------------
// cmws_pkg
// Shared types and constants of the column melt wipe sequencer.
// ----------------------------------------------------------------------------
package cmws_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OS_ZERO,
    OS_DONE_ONE,
    OS_DONE_SCAN,
    OS_QUERY
  } out_sel_t;

  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;

  localparam int COLUMN_COUNT_RESET = 160;
  localparam int ROW_COUNT_RESET    = 200;

  localparam int MELT_FAST_LIMIT = 16;
  localparam int MELT_SLOW_STEP  = 8;

  typedef struct packed {
    logic     capture;
    logic     wr_item;
    logic     rd_item;
    logic     scan_start;
    logic     rd_scan;
    logic     wr_scan;
    logic     next_col;
    logic     next_tick;
    logic     out_load;
    logic     to_hold;
    logic     hold_move;
    out_sel_t out_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic reps_zero;
    logic last_col;
    logic last_tick;
  } dp_sts_t;

endpackage

// ===== rtl/core/cmws_dp.sv =====
// ----------------------------------------------------------------------------
// cmws_dp
// Datapath: config registers, position memory, tick update, query and result.
// ----------------------------------------------------------------------------
module cmws_dp
  import cmws_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_column,
  input  logic [7:0]        in_row,
  input  logic signed [4:0] in_start_offset,
  input  logic [3:0]        in_repeat_req,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  ctl_cmd_t          ctl,
  output dp_sts_t           sts,
  output logic              out_done_res,
  output logic              out_from_end,
  output logic [7:0]        out_source_row
);

  localparam int AW    = $clog2(MAX_COLUMNS);
  localparam int CCW   = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int POS_W = (ROW_W + 1 > 5) ? ROW_W + 1 : 5;
  localparam int SW    = POS_W + 6;
  localparam int COL_RST = (COLUMN_COUNT_RESET > MAX_COLUMNS) ? MAX_COLUMNS
                                                                : COLUMN_COUNT_RESET;
  localparam int ROW_RST = (ROW_COUNT_RESET > MAX_ROWS) ? MAX_ROWS : ROW_COUNT_RESET;

  logic signed [POS_W-1:0] mem [MAX_COLUMNS];
  logic signed [POS_W-1:0] mem_q_r;

  logic [CCW-1:0]   colcnt_r;
  logic [ROW_W-1:0] rowcnt_r;
  logic [7:0]       row_r;
  logic             qry_inr_r;
  logic [AW-1:0]    scan_col_r;
  logic [3:0]       tick_r;
  logic [3:0]       reps_r;
  logic             moved_r;
  logic             done_r;
  logic             from_end_r;
  logic [7:0]       src_row_r;
  logic             hold_done_r;
  logic             hold_from_end_r;
  logic [7:0]       hold_src_row_r;

  logic [AW-1:0]           in_addr;
  logic                    in_range;
  logic signed [4:0]       off_c;
  logic signed [SW-1:0]    p_x;
  logic signed [SW-1:0]    rows_x;
  logic signed [SW-1:0]    dy_x;
  logic signed [SW-1:0]    sum_x;
  logic signed [SW-1:0]    new_x;
  logic signed [POS_W-1:0] new_pos;
  logic                    moved_now;
  logic signed [SW-1:0]    pq_x;
  logic signed [SW-1:0]    row_x;
  logic signed [SW-1:0]    diff_x;
  logic                    q_from_end;
  logic [7:0]              q_src_row;
  logic                    res_done;
  logic                    res_from_end;
  logic [7:0]              res_src_row;

  assign cfg_ready = 1'b1;
  assign in_addr   = AW'(in_column);
  assign in_range  = 32'(in_column) < MAX_COLUMNS;

  always_comb begin
    if (!in_start_offset[4]) begin
      off_c = '0;
    end else if (in_start_offset == -5'sd16) begin
      off_c = -5'sd15;
    end else begin
      off_c = in_start_offset;
    end
  end

  always_comb begin
    p_x       = SW'(mem_q_r);
    rows_x    = signed'(SW'({1'b0, rowcnt_r}));
    dy_x      = '0;
    sum_x     = '0;
    new_x     = p_x;
    moved_now = 1'b0;
    if (p_x < 0) begin
      new_x     = p_x + SW'(1);
      moved_now = 1'b1;
    end else if (p_x < rows_x) begin
      dy_x      = (p_x < SW'(MELT_FAST_LIMIT)) ? p_x + SW'(1) : SW'(MELT_SLOW_STEP);
      sum_x     = p_x + dy_x;
      new_x     = (sum_x >= rows_x) ? rows_x : sum_x;
      moved_now = 1'b1;
    end
    new_pos = POS_W'(new_x);
  end

  always_comb begin
    pq_x       = (qry_inr_r && !mem_q_r[POS_W-1]) ? SW'(mem_q_r) : '0;
    row_x      = signed'(SW'({1'b0, row_r}));
    diff_x     = row_x - pq_x;
    q_from_end = row_x < pq_x;
    q_src_row  = q_from_end ? row_r : diff_x[7:0];
  end

  always_comb begin
    case (ctl.out_sel)
      OS_DONE_ONE: begin
        res_done     = 1'b1;
        res_from_end = 1'b0;
        res_src_row  = '0;
      end
      OS_DONE_SCAN: begin
        res_done     = !(moved_r | moved_now);
        res_from_end = 1'b0;
        res_src_row  = '0;
      end
      OS_QUERY: begin
        res_done     = 1'b0;
        res_from_end = q_from_end;
        res_src_row  = q_src_row;
      end
      default: begin
        res_done     = 1'b0;
        res_from_end = 1'b0;
        res_src_row  = '0;
      end
    endcase
  end

  assign sts.reps_zero = (in_repeat_req == 4'd0);
  assign sts.last_col  = (CCW'(scan_col_r) + CCW'(1)) == colcnt_r;
  assign sts.last_tick = ({1'b0, tick_r} + 5'd1) == {1'b0, reps_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colcnt_r <= CCW'(COL_RST);
      rowcnt_r <= ROW_W'(ROW_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMN_COUNT: begin
          if (cfg_data == 9'd0) begin
            colcnt_r <= CCW'(1);
          end else if (32'(cfg_data) > MAX_COLUMNS) begin
            colcnt_r <= CCW'(MAX_COLUMNS);
          end else begin
            colcnt_r <= CCW'(cfg_data);
          end
        end
        CFG_ROW_COUNT: begin
          if (cfg_data == 9'd0) begin
            rowcnt_r <= ROW_W'(1);
          end else if (32'(cfg_data) > MAX_ROWS) begin
            rowcnt_r <= ROW_W'(MAX_ROWS);
          end else begin
            rowcnt_r <= ROW_W'(cfg_data);
          end
        end
        default: ;
      endcase
    end
  end

  // position memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_item && in_range) begin
      mem[in_addr] <= POS_W'(off_c);
    end else if (ctl.wr_scan) begin
      mem[scan_col_r] <= new_pos;
    end
    if (ctl.rd_item) begin
      mem_q_r <= mem[in_addr];
    end else if (ctl.rd_scan) begin
      mem_q_r <= mem[scan_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      row_r     <= in_row;
      qry_inr_r <= in_range;
      reps_r    <= in_repeat_req;
    end
    if (ctl.scan_start) begin
      scan_col_r <= '0;
      tick_r     <= '0;
      moved_r    <= 1'b0;
    end else begin
      if (ctl.next_tick) begin
        scan_col_r <= '0;
        tick_r     <= tick_r + 4'd1;
      end else if (ctl.next_col) begin
        scan_col_r <= scan_col_r + AW'(1);
      end
      if (ctl.wr_scan) begin
        moved_r <= moved_r | moved_now;
      end
    end
    // result register, backed by one holding register
    if (ctl.hold_move) begin
      done_r     <= hold_done_r;
      from_end_r <= hold_from_end_r;
      src_row_r  <= hold_src_row_r;
    end else if (ctl.out_load && !ctl.to_hold) begin
      done_r     <= res_done;
      from_end_r <= res_from_end;
      src_row_r  <= res_src_row;
    end
    if (ctl.to_hold) begin
      hold_done_r     <= res_done;
      hold_from_end_r <= res_from_end;
      hold_src_row_r  <= res_src_row;
    end
  end

  assign out_done_res   = done_r;
  assign out_from_end   = from_end_r;
  assign out_source_row = src_row_r;

endmodule

// ===== rtl/core/cmws_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmws_ctrl
// Controller: item acceptance, advance scan sequencing, result valid.
// ----------------------------------------------------------------------------
module cmws_ctrl
  import cmws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_sts_t    sts,
  output ctl_cmd_t   ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QRY,
    S_ADV_RD,
    S_ADV_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   hold_valid_r, hold_valid_nxt;
  logic   in_acc;
  logic   out_acc;

  assign in_stall = !((state_r == S_IDLE) && !hold_valid_r);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.capture = 1'b1;
          case (cmd_t'(in_command))
            CMD_WRITE: begin
              ctl.wr_item  = 1'b1;
              ctl.out_load = 1'b1;
              ctl.out_sel  = OS_ZERO;
            end
            CMD_ADVANCE: begin
              if (sts.reps_zero) begin
                ctl.out_load = 1'b1;
                ctl.out_sel  = OS_DONE_ONE;
              end else begin
                ctl.scan_start = 1'b1;
                state_nxt      = S_ADV_RD;
              end
            end
            CMD_QUERY: begin
              ctl.rd_item = 1'b1;
              state_nxt   = S_QRY;
            end
            default: begin
              ctl.out_load = 1'b1;
              ctl.out_sel  = OS_ZERO;
            end
          endcase
        end
      end
      S_QRY: begin
        ctl.out_load = 1'b1;
        ctl.out_sel  = OS_QUERY;
        state_nxt    = S_IDLE;
      end
      S_ADV_RD: begin
        ctl.rd_scan = 1'b1;
        state_nxt   = S_ADV_WR;
      end
      S_ADV_WR: begin
        ctl.wr_scan = 1'b1;
        if (sts.last_col) begin
          if (sts.last_tick) begin
            ctl.out_load = 1'b1;
            ctl.out_sel  = OS_DONE_SCAN;
            state_nxt    = S_IDLE;
          end else begin
            ctl.next_tick = 1'b1;
            state_nxt     = S_ADV_RD;
          end
        end else begin
          ctl.next_col = 1'b1;
          state_nxt    = S_ADV_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ctl.to_hold    = ctl.out_load && out_valid_r && out_stall;
    ctl.hold_move  = hold_valid_r && out_acc;
    out_valid_nxt  = (ctl.out_load || hold_valid_r) ? 1'b1 :
                     (out_acc ? 1'b0 : out_valid_r);
    hold_valid_nxt = ctl.to_hold ? 1'b1 : (out_acc ? 1'b0 : hold_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> !hold_valid_r)
    else $error("result loaded while holding register is full");

  a_hold_order: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("holding register full with empty result register");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV_WR && ctl.out_load) |-> (sts.last_col && sts.last_tick))
    else $error("advance finished before last column of last tick");

  a_query_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_command == CMD_QUERY) |=> (state_r == S_QRY && in_stall))
    else $error("query did not enter result cycle");

  a_scan_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV_RD || state_r == S_ADV_WR) |-> in_stall)
    else $error("item accepted during advance scan");

endmodule

// ===== rtl/core/column_melt_wipe_sequencer.sv =====
// ----------------------------------------------------------------------------
// column_melt_wipe_sequencer
// Melt wipe position keeper with write, advance and pixel source query items.
// ----------------------------------------------------------------------------
// Write items and unknown commands give their result from S_IDLE, queries
// from S_QRY; an advance item updates column_count columns repeat_req times
// (result from S_IDLE if that is zero), each column a read-modify-write on
// the single position memory, read in S_ADV_RD and written back in S_ADV_WR.
// The input stalls while a query or advance is in progress. A finished
// result waits in the output register, backed by one holding register, so
// the next item is taken while a result is held off; the input stalls only
// once both are full. The position memory gets no clearing after reset;
// columns must be written before use, by the user; it is not enforced.
module column_melt_wipe_sequencer
  import cmws_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_column,
  input  logic [7:0]        in_row,
  input  logic signed [4:0] in_start_offset,
  input  logic [3:0]        in_repeat_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_done_res,
  output logic              out_from_end,
  output logic [7:0]        out_source_row,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data
);

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  cmws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  cmws_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_start_offset (in_start_offset),
    .in_repeat_req   (in_repeat_req),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ctl             (ctl),
    .sts             (sts),
    .out_done_res    (out_done_res),
    .out_from_end    (out_from_end),
    .out_source_row  (out_source_row)
  );

endmodule
